FILE: src/tscs_pkg.sv
// Package: shared types, constants and codes of the time-slice context scheduler.
`default_nettype none
package tscs_pkg;

   localparam int MAX_SLOTS = 8;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int LEN_W     = SLOT_W + 1;
   localparam int TIME_W    = 32;
   localparam int REQ_DW    = 40;
   localparam int RSP_DW    = 16;
   localparam int CSR_AW    = 4;

   localparam logic [19:0]    MAX_PERIOD_RST = 20'd1000;
   localparam logic [7:0]     MIN_RUN_RST    = 8'd10;
   localparam logic [3:0]     SLOT_LIMIT_RST = 4'd8;
   localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_SLOTS);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_COMMIT = 2'd1,
      PH_HW     = 2'd2,
      PH_RSVD   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_COMMIT  = 3'd1,
      ACT_ENABLE  = 3'd2,
      ACT_DISABLE = 3'd3,
      ACT_SRESET  = 3'd4,
      ACT_ATTACH  = 3'd5,
      ACT_DETACH  = 3'd6,
      ACT_NOP     = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      STOP_NONE   = 3'd0,
      STOP_FINISH = 3'd1,
      STOP_ABORT  = 3'd2,
      STOP_PAUSE  = 3'd3,
      STOP_RESET  = 3'd4
   } stop_type;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_ATTACH = 2'd1,
      ERR_DETACH = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      POL_RR         = 2'd0,
      POL_FAIR_ABORT = 2'd1,
      POL_FAIR_PAUSE = 2'd2,
      POL_RSVD       = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      REG_POLICY     = 2'd0,
      REG_MAX_PERIOD = 2'd1,
      REG_MIN_RUN    = 2'd2,
      REG_SLOT_LIMIT = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DECIDE,
      ST_RETIRE,
      ST_FIND,
      ST_PLACE,
      ST_APPEND,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DUR,
      OP_CHARGE,
      OP_RETIRE,
      OP_STILL,
      OP_NEXT,
      OP_REMOVE,
      OP_INSERT,
      OP_APPEND,
      OP_RUN,
      OP_ATTACH,
      OP_DETACH,
      OP_ERR,
      OP_COMMIT,
      OP_ENABLE,
      OP_DISABLE,
      OP_SRESET,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      RD_S,
      RD_TGT,
      RD_LIST
   } rd_sel_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
      stop_type   kind;
      err_type    err;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       hw_idle;
      policy_type policy;
      logic       cur_present;
      logic       attached;
      logic       enabled;
      phase_type  phase;
      logic       idx_end;
      logic       hit_tgt;
      logic       hit_gt;
      logic       dur_lt_min;
      logic       dur_le_max;
      logic       full;
      logic       out_busy;
   } status_type;

   typedef struct packed {
      policy_type  policy;
      logic [19:0] max_period;
      logic [7:0]  min_run;
      logic [3:0]  slot_limit;
   } cfg_type;

endpackage
`default_nettype wire

FILE: src/tscs_csr.sv
// Configuration register file on the APB-style port.
`default_nettype none
module tscs_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [tscs_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready,
   output tscs_pkg::cfg_type                 cfg
);

   tscs_pkg::cfg_type cfg_ff, cfg_in;
   tscs_pkg::reg_type idx;
   logic              wr;

   assign idx        = tscs_pkg::reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            tscs_pkg::REG_POLICY:     cfg_in.policy     = tscs_pkg::policy_type'(csr_pwdata[1:0]);
            tscs_pkg::REG_MAX_PERIOD: cfg_in.max_period = csr_pwdata[19:0];
            tscs_pkg::REG_MIN_RUN:    cfg_in.min_run    = csr_pwdata[7:0];
            tscs_pkg::REG_SLOT_LIMIT: cfg_in.slot_limit = csr_pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         tscs_pkg::REG_POLICY:     csr_prdata = {30'd0, cfg_ff.policy};
         tscs_pkg::REG_MAX_PERIOD: csr_prdata = {12'd0, cfg_ff.max_period};
         tscs_pkg::REG_MIN_RUN:    csr_prdata = {24'd0, cfg_ff.min_run};
         tscs_pkg::REG_SLOT_LIMIT: csr_prdata = {28'd0, cfg_ff.slot_limit};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy     <= tscs_pkg::POL_RR;
         cfg_ff.max_period <= tscs_pkg::MAX_PERIOD_RST;
         cfg_ff.min_run    <= tscs_pkg::MIN_RUN_RST;
         cfg_ff.slot_limit <= tscs_pkg::SLOT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/tscs_ctrl.sv
// Controller state machine: sequences one beat through the datapath.
`default_nettype none
module tscs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire tscs_pkg::status_type  status,
   output tscs_pkg::cmd_type          cmd
);

   tscs_pkg::state_type state_ff, state_in;
   logic                fair;
   tscs_pkg::stop_type  kind;

   assign fair = (status.policy == tscs_pkg::POL_FAIR_ABORT) ||
                 (status.policy == tscs_pkg::POL_FAIR_PAUSE);

   always_comb begin
      if (fair && !status.hw_idle)
         kind = (status.policy == tscs_pkg::POL_FAIR_ABORT) ? tscs_pkg::STOP_ABORT
                                                            : tscs_pkg::STOP_PAUSE;
      else
         kind = tscs_pkg::STOP_FINISH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tscs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.op     = tscs_pkg::OP_NONE;
      cmd.rd_sel = tscs_pkg::RD_TGT;
      cmd.kind   = tscs_pkg::STOP_FINISH;
      cmd.err    = tscs_pkg::ERR_OK;
      unique case (state_ff)
         tscs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = tscs_pkg::OP_LOAD;
               state_in = tscs_pkg::ST_EXEC;
            end
         end
         tscs_pkg::ST_EXEC: begin
            state_in = tscs_pkg::ST_DONE;
            unique case (status.action)
               tscs_pkg::ACT_TICK: begin
                  if (!status.cur_present) begin
                     state_in = tscs_pkg::ST_SCAN;
                  end else if (!status.enabled || status.phase != tscs_pkg::PH_HW) begin
                     cmd.op   = tscs_pkg::OP_RETIRE;
                     cmd.kind = tscs_pkg::STOP_FINISH;
                     state_in = tscs_pkg::ST_SCAN;
                  end else begin
                     cmd.op   = tscs_pkg::OP_DUR;
                     state_in = tscs_pkg::ST_DECIDE;
                  end
               end
               tscs_pkg::ACT_ATTACH: begin
                  if (status.attached || status.full) begin
                     cmd.op  = tscs_pkg::OP_ERR;
                     cmd.err = tscs_pkg::ERR_ATTACH;
                  end else begin
                     cmd.op = tscs_pkg::OP_ATTACH;
                  end
               end
               tscs_pkg::ACT_DETACH: begin
                  if (!status.attached) begin
                     cmd.op  = tscs_pkg::OP_ERR;
                     cmd.err = tscs_pkg::ERR_DETACH;
                  end else begin
                     cmd.op   = tscs_pkg::OP_DETACH;
                     state_in = tscs_pkg::ST_FIND;
                  end
               end
               tscs_pkg::ACT_COMMIT:  if (status.attached) cmd.op = tscs_pkg::OP_COMMIT;
               tscs_pkg::ACT_ENABLE:  if (status.attached) cmd.op = tscs_pkg::OP_ENABLE;
               tscs_pkg::ACT_DISABLE: if (status.attached) cmd.op = tscs_pkg::OP_DISABLE;
               tscs_pkg::ACT_SRESET:  if (status.attached) cmd.op = tscs_pkg::OP_SRESET;
               tscs_pkg::ACT_NOP:     cmd.op = tscs_pkg::OP_NONE;
            endcase
         end
         tscs_pkg::ST_DECIDE: begin
            if ((!fair && !status.hw_idle) || status.dur_lt_min ||
                (fair && !status.hw_idle && status.dur_le_max)) begin
               cmd.op   = tscs_pkg::OP_STILL;
               state_in = tscs_pkg::ST_DONE;
            end else begin
               cmd.op   = tscs_pkg::OP_CHARGE;
               state_in = tscs_pkg::ST_RETIRE;
            end
         end
         tscs_pkg::ST_RETIRE: begin
            cmd.op   = tscs_pkg::OP_RETIRE;
            cmd.kind = kind;
            state_in = tscs_pkg::ST_FIND;
         end
         tscs_pkg::ST_FIND: begin
            cmd.rd_sel = tscs_pkg::RD_LIST;
            if (status.idx_end || status.hit_tgt) begin
               if (status.hit_tgt) cmd.op = tscs_pkg::OP_REMOVE;
               if (status.action != tscs_pkg::ACT_TICK)
                  state_in = tscs_pkg::ST_DONE;
               else if (fair)
                  state_in = tscs_pkg::ST_PLACE;
               else
                  state_in = tscs_pkg::ST_APPEND;
            end else begin
               cmd.op = tscs_pkg::OP_NEXT;
            end
         end
         tscs_pkg::ST_PLACE: begin
            cmd.rd_sel = tscs_pkg::RD_LIST;
            if (status.idx_end || status.hit_gt) begin
               cmd.op   = tscs_pkg::OP_INSERT;
               state_in = tscs_pkg::ST_SCAN;
            end else begin
               cmd.op = tscs_pkg::OP_NEXT;
            end
         end
         tscs_pkg::ST_APPEND: begin
            cmd.op   = tscs_pkg::OP_APPEND;
            state_in = tscs_pkg::ST_SCAN;
         end
         tscs_pkg::ST_SCAN: begin
            cmd.rd_sel = tscs_pkg::RD_LIST;
            if (status.idx_end) begin
               state_in = tscs_pkg::ST_DONE;
            end else if (status.phase == tscs_pkg::PH_COMMIT) begin
               cmd.op   = tscs_pkg::OP_RUN;
               state_in = tscs_pkg::ST_DONE;
            end else begin
               cmd.op = tscs_pkg::OP_NEXT;
            end
         end
         tscs_pkg::ST_DONE: begin
            cmd.rd_sel = tscs_pkg::RD_S;
            if (!status.out_busy) begin
               cmd.op   = tscs_pkg::OP_FINISH;
               state_in = tscs_pkg::ST_IDLE;
            end
         end
         default: state_in = tscs_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/tscs_dp.sv
// Datapath: slot table, order list, walk pointer and result register.
`default_nettype none
module tscs_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tscs_pkg::cmd_type             cmd,
   input  wire tscs_pkg::cfg_type             cfg,
   input  wire logic [tscs_pkg::REQ_DW-1:0]   req_tdata,
   input  wire logic [2:0]                    req_tuser,
   output tscs_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [tscs_pkg::RSP_DW-1:0]   rsp_tdata
);

   localparam int N  = tscs_pkg::MAX_SLOTS;
   localparam int SW = tscs_pkg::SLOT_W;
   localparam int LW = tscs_pkg::LEN_W;
   localparam int TW = tscs_pkg::TIME_W;

   // slot table
   logic                att_ff   [N], att_in   [N];
   logic                en_ff    [N], en_in    [N];
   tscs_pkg::phase_type ph_ff    [N], ph_in    [N];
   logic [TW-1:0]       start_ff [N], start_in [N];
   logic [TW-1:0]       tot_ff   [N], tot_in   [N];
   logic [SW-1:0]       list_ff  [N], list_in  [N];
   logic [LW-1:0]       len_ff, len_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic                pres_ff, pres_in;

   // item and walk
   tscs_pkg::action_type act_ff, act_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [TW-1:0]       now_ff, now_in;
   logic                idle_ff, idle_in;
   logic [SW-1:0]       tgt_ff, tgt_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic [TW-1:0]       dur_ff, dur_in;
   logic [TW-1:0]       ttot_ff, ttot_in;

   // partial result
   tscs_pkg::stop_type  stop_ff, stop_in;
   logic [SW-1:0]       sslot_ff, sslot_in;
   logic                runv_ff, runv_in;
   logic [SW-1:0]       rslot_ff, rslot_in;
   logic                still_ff, still_in;
   tscs_pkg::err_type   err_ff, err_in;

   logic                ovalid_ff, ovalid_in;
   logic [tscs_pkg::RSP_DW-1:0] odata_ff, odata_in;

   logic [SW-1:0]       rd;
   logic [SW-1:0]       list_v;
   logic [SW-1:0]       pos;
   logic [TW:0]         sum;
   logic [LW-1:0]       lim;

   assign list_v = list_ff[idx_ff[SW-1:0]];
   assign pos    = idx_ff[SW-1:0];
   assign sum    = {1'b0, tot_ff[tgt_ff]} + {1'b0, dur_ff};
   assign lim    = (cfg.slot_limit > tscs_pkg::SLOT_LIMIT_RST) ? tscs_pkg::MAX_LEN
                                                               : LW'(cfg.slot_limit);

   always_comb begin
      unique case (cmd.rd_sel)
         tscs_pkg::RD_S:    rd = s_ff;
         tscs_pkg::RD_TGT:  rd = tgt_ff;
         tscs_pkg::RD_LIST: rd = list_v;
         default:           rd = tgt_ff;
      endcase
   end

   always_comb begin
      status.action      = act_ff;
      status.hw_idle     = idle_ff;
      status.policy      = cfg.policy;
      status.cur_present = pres_ff;
      status.attached    = att_ff[rd];
      status.enabled     = en_ff[rd];
      status.phase       = ph_ff[rd];
      status.idx_end     = (idx_ff >= len_ff);
      status.hit_tgt     = (list_v == tgt_ff);
      status.hit_gt      = (tot_ff[rd] > ttot_ff);
      status.dur_lt_min  = (dur_ff < {{(TW-8){1'b0}}, cfg.min_run});
      status.dur_le_max  = (dur_ff <= {{(TW-20){1'b0}}, cfg.max_period});
      status.full        = (len_ff >= lim);
      status.out_busy    = ovalid_ff & ~rsp_tready;
   end

   always_comb begin
      att_in   = att_ff;
      en_in    = en_ff;
      ph_in    = ph_ff;
      start_in = start_ff;
      tot_in   = tot_ff;
      list_in  = list_ff;
      len_in   = len_ff;
      cur_in   = cur_ff;
      pres_in  = pres_ff;
      act_in   = act_ff;
      s_in     = s_ff;
      now_in   = now_ff;
      idle_in  = idle_ff;
      tgt_in   = tgt_ff;
      idx_in   = idx_ff;
      dur_in   = dur_ff;
      ttot_in  = ttot_ff;
      stop_in  = stop_ff;
      sslot_in = sslot_ff;
      runv_in  = runv_ff;
      rslot_in = rslot_ff;
      still_in = still_ff;
      err_in   = err_ff;
      ovalid_in = ovalid_ff & ~rsp_tready;
      odata_in  = odata_ff;
      unique case (cmd.op)
         tscs_pkg::OP_NONE: ;
         tscs_pkg::OP_LOAD: begin
            act_in   = tscs_pkg::action_type'(req_tuser);
            s_in     = req_tdata[2:0];
            now_in   = req_tdata[34:3];
            idle_in  = req_tdata[35];
            tgt_in   = (tscs_pkg::action_type'(req_tuser) == tscs_pkg::ACT_TICK) ? cur_ff
                                                                                 : req_tdata[2:0];
            idx_in   = '0;
            stop_in  = tscs_pkg::STOP_NONE;
            sslot_in = '0;
            runv_in  = 1'b0;
            rslot_in = '0;
            still_in = 1'b0;
            err_in   = tscs_pkg::ERR_OK;
         end
         tscs_pkg::OP_DUR: dur_in = now_ff - start_ff[tgt_ff];
         tscs_pkg::OP_CHARGE: begin
            tot_in[tgt_ff] = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            ttot_in        = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
         end
         tscs_pkg::OP_RETIRE: begin
            ph_in[tgt_ff]    = tscs_pkg::PH_IDLE;
            start_in[tgt_ff] = '0;
            pres_in          = 1'b0;
            stop_in          = cmd.kind;
            sslot_in         = tgt_ff;
         end
         tscs_pkg::OP_STILL: still_in = 1'b1;
         tscs_pkg::OP_NEXT:  idx_in   = idx_ff + 1'b1;
         tscs_pkg::OP_REMOVE: begin
            for (int i = 0; i < N - 1; i++)
               if (i >= int'(pos)) list_in[i] = list_ff[i+1];
            len_in = len_ff - 1'b1;
            idx_in = '0;
         end
         tscs_pkg::OP_INSERT: begin
            for (int i = 1; i < N; i++)
               if (i > int'(pos)) list_in[i] = list_ff[i-1];
            list_in[pos] = tgt_ff;
            len_in = len_ff + 1'b1;
            idx_in = '0;
         end
         tscs_pkg::OP_APPEND: begin
            list_in[len_ff[SW-1:0]] = tgt_ff;
            len_in = len_ff + 1'b1;
            idx_in = '0;
         end
         tscs_pkg::OP_RUN: begin
            start_in[list_v] = now_ff;
            ph_in[list_v]    = tscs_pkg::PH_HW;
            cur_in           = list_v;
            pres_in          = 1'b1;
            runv_in          = 1'b1;
            rslot_in         = list_v;
         end
         tscs_pkg::OP_ATTACH: begin
            att_in[tgt_ff]   = 1'b1;
            en_in[tgt_ff]    = 1'b0;
            ph_in[tgt_ff]    = tscs_pkg::PH_IDLE;
            start_in[tgt_ff] = '0;
            tot_in[tgt_ff]   = '0;
            for (int i = 1; i < N; i++) list_in[i] = list_ff[i-1];
            list_in[0] = tgt_ff;
            len_in = len_ff + 1'b1;
         end
         tscs_pkg::OP_DETACH: begin
            att_in[tgt_ff] = 1'b0;
            en_in[tgt_ff]  = 1'b0;
            ph_in[tgt_ff]  = tscs_pkg::PH_IDLE;
            if (pres_ff && cur_ff == tgt_ff) pres_in = 1'b0;
         end
         tscs_pkg::OP_ERR:     err_in = cmd.err;
         tscs_pkg::OP_COMMIT:  ph_in[tgt_ff] = tscs_pkg::PH_COMMIT;
         tscs_pkg::OP_ENABLE:  en_in[tgt_ff] = 1'b1;
         tscs_pkg::OP_DISABLE: en_in[tgt_ff] = 1'b0;
         tscs_pkg::OP_SRESET: begin
            if (ph_ff[tgt_ff] == tscs_pkg::PH_HW) begin
               pres_in  = 1'b0;
               stop_in  = tscs_pkg::STOP_RESET;
               sslot_in = tgt_ff;
            end
            ph_in[tgt_ff] = tscs_pkg::PH_IDLE;
         end
         tscs_pkg::OP_FINISH: begin
            ovalid_in = 1'b1;
            odata_in  = {pres_ff, ph_ff[s_ff], err_ff, still_ff, rslot_ff, runv_ff,
                         sslot_ff, stop_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            att_ff[i] <= 1'b0;
            en_ff[i]  <= 1'b0;
            ph_ff[i]  <= tscs_pkg::PH_IDLE;
         end
         len_ff    <= '0;
         cur_ff    <= '0;
         pres_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         att_ff    <= att_in;
         en_ff     <= en_in;
         ph_ff     <= ph_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
         pres_ff   <= pres_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      tot_ff   <= tot_in;
      list_ff  <= list_in;
      act_ff   <= act_in;
      s_ff     <= s_in;
      now_ff   <= now_in;
      idle_ff  <= idle_in;
      tgt_ff   <= tgt_in;
      idx_ff   <= idx_in;
      dur_ff   <= dur_in;
      ttot_ff  <= ttot_in;
      stop_ff  <= stop_in;
      sslot_ff <= sslot_in;
      runv_ff  <= runv_in;
      rslot_ff <= rslot_in;
      still_ff <= still_in;
      err_ff   <= err_in;
      odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

endmodule
`default_nettype wire

FILE: src/time_slice_context_scheduler.sv
// Top level: time-slice context scheduler for slots on one shared accelerator.
// Detach walks the order list to find the slot; a tick may walk it to find the slot,
// then place it by total (fair policies) or append it (other policies), and scan it for
// a committed slot to start; each walk covers at most 8 entries, one entry per cycle.
// Throughput: one beat at a time; the next beat is taken once the result is loaded.
// Reset: synchronous; clears slot flags, phases, list length and current slot.
// No clearing pass; registers return to policy 0, 1000, 10, 8.
`default_nettype none
module time_slice_context_scheduler (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [2:0] slot, [34:3] now_ms, [35] hw_idle, [39:36] zero
   input  wire logic [tscs_pkg::REQ_DW-1:0]  req_tdata,
   // [2:0] action
   input  wire logic [2:0]                   req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [2:0] stop_kind, [5:3] stop_slot, [6] run_valid, [9:7] run_slot,
   // [10] still_running, [12:11] error, [14:13] slot_state, [15] current_valid
   output logic      [tscs_pkg::RSP_DW-1:0]  rsp_tdata,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [tscs_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);

   tscs_pkg::cfg_type    cfg;
   tscs_pkg::cmd_type    cmd;
   tscs_pkg::status_type status;

   tscs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tscs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tscs_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: tb/tb_time_slice_context_scheduler.sv
// Testbench: time-slice context scheduler checked beat by beat against a scheduling predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_time_slice_context_scheduler;
   import tscs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;

   // predicts the scheduler's response beats from accepted event beats
   class SlotScheduleBoard;
      policy_type  pol;
      logic [19:0] max_period;
      logic [7:0]  min_run;
      logic [3:0]  slot_limit;
      logic [2:0]  order[MAX_SLOTS];
      int          len;
      bit          attached[MAX_SLOTS];
      bit          enabled[MAX_SLOTS];
      phase_type   phase[MAX_SLOTS];
      logic [31:0] start_ms[MAX_SLOTS];
      logic [31:0] total_ms[MAX_SLOTS];
      logic [2:0]  cur;
      bit          cur_on;
      logic [RSP_DW-1:0] pending[$];
      int          fails;

      function new();
         pol = POL_RR; max_period = MAX_PERIOD_RST; min_run = MIN_RUN_RST;
         slot_limit = SLOT_LIMIT_RST; len = 0; cur = '0; cur_on = 0; fails = 0;
         for (int k = 0; k < MAX_SLOTS; k++) begin
            order[k] = '0; attached[k] = 0; enabled[k] = 0; phase[k] = PH_IDLE;
            start_ms[k] = '0; total_ms[k] = '0;
         end
      endfunction

      function void set_reg(reg_type r, logic [31:0] v);
         case (r)
            REG_POLICY:     pol = policy_type'(v[1:0]);
            REG_MAX_PERIOD: max_period = v[19:0];
            REG_MIN_RUN:    min_run = v[7:0];
            default:        slot_limit = v[3:0];
         endcase
      endfunction

      function void drop(logic [2:0] s);
         int j;
         j = 0;
         for (int k = 0; k < len; k++)
            if (order[k] != s) begin
               order[j] = order[k];
               j++;
            end
         len = j;
      endfunction

      function void put(int pos, logic [2:0] s);
         if (len >= MAX_SLOTS || pos > len) return;
         for (int k = len; k > pos; k--) order[k] = order[k-1];
         order[pos] = s;
         len++;
      endfunction

      function void note(action_type a, logic [2:0] s, logic [31:0] now, bit idle);
         stop_type    stop;
         err_type     err;
         logic [2:0]  stop_slot, run_slot, c;
         logic [31:0] dur;
         bit          run_valid, still, scan, fair;
         int          i, cap;
         stop = STOP_NONE; err = ERR_OK; stop_slot = '0; run_slot = '0;
         run_valid = 0; still = 0; scan = 1;
         cap = (slot_limit < MAX_SLOTS) ? slot_limit : MAX_SLOTS;
         case (a)
            ACT_TICK: begin
               if (cur_on) begin
                  c = cur;
                  if (!enabled[c] || phase[c] != PH_HW) begin
                     stop = STOP_FINISH;
                  end else begin
                     dur = now - start_ms[c];
                     fair = (pol == POL_FAIR_ABORT || pol == POL_FAIR_PAUSE);
                     if (!fair && !idle) scan = 0;
                     else if (dur < min_run) scan = 0;
                     else if (fair && !idle && dur <= max_period) scan = 0;
                     else begin
                        if (fair && !idle)
                           stop = (pol == POL_FAIR_ABORT) ? STOP_ABORT : STOP_PAUSE;
                        else
                           stop = STOP_FINISH;
                        if (dur > 32'hFFFF_FFFF - total_ms[c]) total_ms[c] = 32'hFFFF_FFFF;
                        else total_ms[c] = total_ms[c] + dur;
                        drop(c);
                        if (fair) begin
                           for (i = 0; i < len; i++)
                              if (total_ms[order[i]] > total_ms[c]) break;
                           put(i, c);
                        end else begin
                           put(len, c);
                        end
                     end
                  end
                  if (stop != STOP_NONE) begin
                     start_ms[c] = '0;
                     phase[c] = PH_IDLE;
                     cur_on = 0;
                     stop_slot = c;
                  end else begin
                     still = 1;
                  end
               end
               if (scan)
                  for (i = 0; i < len; i++)
                     if (phase[order[i]] == PH_COMMIT) begin
                        start_ms[order[i]] = now;
                        phase[order[i]] = PH_HW;
                        cur = order[i];
                        cur_on = 1;
                        run_valid = 1;
                        run_slot = order[i];
                        break;
                     end
            end
            ACT_ATTACH: begin
               if (attached[s] || len >= cap) begin
                  err = ERR_ATTACH;
               end else begin
                  attached[s] = 1; enabled[s] = 0; phase[s] = PH_IDLE;
                  start_ms[s] = '0; total_ms[s] = '0;
                  put(0, s);
               end
            end
            ACT_DETACH: begin
               if (!attached[s]) begin
                  err = ERR_DETACH;
               end else begin
                  drop(s);
                  attached[s] = 0; enabled[s] = 0; phase[s] = PH_IDLE;
                  if (cur_on && cur == s) cur_on = 0;
               end
            end
            default: begin
               if (attached[s])
                  case (a)
                     ACT_COMMIT:  phase[s] = PH_COMMIT;
                     ACT_ENABLE:  enabled[s] = 1;
                     ACT_DISABLE: enabled[s] = 0;
                     ACT_SRESET: begin
                        if (phase[s] == PH_HW) begin
                           cur_on = 0;
                           stop = STOP_RESET;
                           stop_slot = s;
                        end
                        phase[s] = PH_IDLE;
                     end
                     default: ;
                  endcase
            end
         endcase
         pending.push_back({cur_on, phase[s], err, still, run_slot, run_valid, stop_slot, stop});
      endfunction

      function void check(logic [RSP_DW-1:0] got);
         int lo[8] = '{0, 3, 6, 7, 10, 11, 13, 15};
         int w[8]  = '{3, 3, 1, 3, 1, 2, 2, 1};
         string names[8] = '{"stop_kind", "stop_slot", "run_valid", "run_slot",
                             "still_running", "error", "slot_state", "current_valid"};
         logic [RSP_DW-1:0] exp_beat, mask;
         bit bad;
         if (pending.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected response beat %h", got);
            return;
         end
         exp_beat = pending.pop_front();
         bad = 0;
         for (int f = 0; f < 8; f++) begin
            mask = RSP_DW'(((1 << w[f]) - 1) << lo[f]);
            if ((exp_beat & mask) !== (got & mask)) begin
               if (!bad) fails++;
               bad = 1;
               if (fails <= 10)
                  $display("%s: expected %0d got %0d", names[f],
                           (exp_beat & mask) >> lo[f], (got & mask) >> lo[f]);
            end
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [2:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   SlotScheduleBoard board;
   bit quiet;
   int stall_left;
   int cycles;
   logic [31:0] now_ms;

   time_slice_context_scheduler i_dut (.*);

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("time_slice_context_scheduler verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check(rsp_tdata);
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_event(action_type a, logic [2:0] s, logic [31:0] t, bit idle);
      req_tvalid <= 1'b1;
      req_tuser  <= a;
      req_tdata  <= {4'b0, idle, t, s};
      do @(posedge clock); while (!req_tready);
      board.note(a, s, t, idle);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic csr_write(reg_type r, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_AW'(r) << 2;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_reg(r, v);
   endtask

   task automatic reconfigure(policy_type p, logic [19:0] mp, logic [7:0] mr, logic [3:0] sl);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write(REG_POLICY, 32'(p));
      csr_write(REG_MAX_PERIOD, 32'(mp));
      csr_write(REG_MIN_RUN, 32'(mr));
      csr_write(REG_SLOT_LIMIT, 32'(sl));
   endtask

   task automatic random_event();
      int pick;
      action_type a;
      pick = $urandom_range(0, 99);
      if (pick < 35)      a = ACT_TICK;
      else if (pick < 55) a = ACT_COMMIT;
      else if (pick < 65) a = ACT_ENABLE;
      else if (pick < 70) a = ACT_DISABLE;
      else if (pick < 75) a = ACT_SRESET;
      else if (pick < 87) a = ACT_ATTACH;
      else if (pick < 97) a = ACT_DETACH;
      else                a = ACT_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 80)      now_ms = now_ms + $urandom_range(0, 40);
      else if (pick < 95) now_ms = now_ms + $urandom_range(0, 2000);
      else                now_ms = $urandom;
      send_event(a, 3'($urandom_range(0, 7)), now_ms, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      board = new();
      quiet = 0; stall_left = 0; cycles = 0; now_ms = '0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = ACT_TICK;
      rsp_tready = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_event(ACT_ATTACH, 3'd0, 32'd0, 1'b1);
      send_event(ACT_ATTACH, 3'd0, 32'd0, 1'b1);
      send_event(ACT_DETACH, 3'd5, 32'd0, 1'b1);
      send_event(ACT_ENABLE, 3'd0, 32'd0, 1'b0);
      send_event(ACT_COMMIT, 3'd0, 32'd0, 1'b0);
      send_event(ACT_TICK, 3'd0, 32'd0, 1'b0);
      send_event(ACT_TICK, 3'd0, 32'd500, 1'b0);
      send_event(ACT_TICK, 3'd0, 32'd505, 1'b1);
      send_event(ACT_COMMIT, 3'd0, 32'd505, 1'b0);
      send_event(ACT_TICK, 3'd7, 32'hFFFF_FFF0, 1'b1);
      send_event(ACT_SRESET, 3'd0, 32'hFFFF_FFFF, 1'b1);
      send_event(ACT_COMMIT, 3'd0, 32'hFFFF_FFFF, 1'b1);
      send_event(ACT_TICK, 3'd0, 32'hFFFF_FFFF, 1'b1);
      send_event(ACT_COMMIT, 3'd0, 32'd20, 1'b1);
      send_event(ACT_TICK, 3'd0, 32'd40, 1'b1);
      send_event(ACT_COMMIT, 3'd0, 32'd40, 1'b1);
      send_event(ACT_TICK, 3'd0, 32'd41, 1'b0);
      send_event(ACT_DISABLE, 3'd0, 32'd41, 1'b0);
      send_event(ACT_TICK, 3'd0, 32'd42, 1'b0);
      send_event(ACT_ENABLE, 3'd0, 32'd42, 1'b0);
      send_event(ACT_COMMIT, 3'd0, 32'd42, 1'b0);
      send_event(ACT_TICK, 3'd0, 32'd43, 1'b0);
      send_event(ACT_DETACH, 3'd0, 32'd43, 1'b0);
      send_event(ACT_NOP, 3'd7, 32'd43, 1'b1);
      send_event(ACT_TICK, 3'd0, 32'd44, 1'b1);

      reconfigure(POL_FAIR_ABORT, 20'd20, 8'd0, 4'd8);
      repeat (100) random_event();
      reconfigure(POL_FAIR_PAUSE, 20'd1, 8'd255, 4'd3);
      repeat (100) random_event();
      reconfigure(POL_RSVD, 20'hFFFFF, 8'd0, 4'd1);
      repeat (80) random_event();
      reconfigure(POL_RR, 20'd1000, 8'd10, 4'd8);
      repeat (100) random_event();
      reconfigure(POL_FAIR_ABORT, 20'd5, 8'd3, 4'd8);
      repeat (110) random_event();
      reconfigure(POL_FAIR_PAUSE, 20'd30, 8'd0, 4'd8);
      quiet = 1;
      repeat (110) random_event();
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.fails == 0)
         $display("time_slice_context_scheduler verification clean");
      else
         $display("time_slice_context_scheduler verification failed");
      $finish;
   end
endmodule
`default_nettype wire

FILE: time_slice_context_scheduler.f
src/tscs_pkg.sv
src/tscs_csr.sv
src/tscs_ctrl.sv
src/tscs_dp.sv
src/time_slice_context_scheduler.sv
tb/tb_time_slice_context_scheduler.sv
